@@ hdl/amt_pkg.sv @@
// Package for the adaptive mean threshold block: geometry constants, widths,
// register indexes and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block imports it.
package amt_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int RADIUS     = 10;
  localparam int LINES      = 2 * RADIUS + 1;
  localparam int AREA       = LINES * LINES;
  localparam int PIX_MAX    = 2 ** PIX_W - 1;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W   = $clog2(LINES);
  localparam int LS_AW    = SLOT_W + COL_W;
  localparam int LS_DEPTH = LINES * MAX_WIDTH;
  localparam int RECV_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LAG_W    = $clog2(MAX_WIDTH * RADIUS + RADIUS + 1);
  localparam int CS_W     = $clog2(LINES * PIX_MAX + 1);
  localparam int WS_W     = $clog2(AREA * PIX_MAX + 1);

  // The mean is the window sum times a rounded-up reciprocal of the area.
  // For sums below 2^WS_W the product shifted down is the exact quotient.
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + AREA - 1) / AREA;
  localparam int RECIP_W     = $clog2(RECIP_MUL + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 13;
  localparam int OFS_W      = 9;
  localparam int LVL_W      = OFS_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET = CFG_IDX_W'(2);

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_OFFSET = 9;

  // Result buffer.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Control for one accepted item, decided from the frame counters.
  typedef struct packed {
    logic             is_pix;     // pixel is stored and enters the sums
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic             row_zero;   // first line of the frame
    logic             row_fresh;  // line slot not yet filled in this frame
    logic             col_zero;
    logic             col_full;   // a column leaves the window on the left
    logic             emit;       // item produces a result
    logic             border;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [WS_W-1:0]  ws;
    logic [PIX_W-1:0] pix;
    logic             border;
    logic             last;
  } sum_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             is_border;
    logic             last_of_frame;
  } res_t;

endpackage

@@ hdl/amt_in_if.sv @@
// Input channel of the adaptive mean threshold block: valid/ready plus payload.
// Depends on amt_pkg for the pixel width.
interface amt_in_if;
  import amt_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, func, pixel_in, input ready);
  modport sink (input valid, func, pixel_in, output ready);
endinterface

@@ hdl/amt_out_if.sv @@
// Result channel of the adaptive mean threshold block: valid/ready plus payload.
// Depends on amt_pkg for the pixel width.
interface amt_out_if;
  import amt_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             is_border;
  logic             last_of_frame;

  modport source (output valid, pixel_out, is_border, last_of_frame, input ready);
  modport sink (input valid, pixel_out, is_border, last_of_frame, output ready);
endinterface

@@ hdl/adaptive_mean_threshold_top.sv @@
// Adaptive mean threshold, top level. One item is accepted per cycle while ready is high; a
// result (R lines plus R pixels behind the item causing it) is offered once that item has
// passed stages s1, s2, s3 and the result buffer. The line store has one write port and two
// read ports. ready drops only while 8 results are buffered or in the three stages.
// Reset (rst, synchronous) restores 640x480, offset 9 and clears counters;
// line store and column sums are not cleared, so no clearing pass is run.
module adaptive_mean_threshold_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [amt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amt_pkg::CFG_DATA_W-1:0] cfg_data,
  amt_in_if.sink                         pixels,
  amt_out_if.source                      results
);
  import amt_pkg::*;

  item_t                   item;
  logic [LS_AW-1:0]        in_addr, out_addr;
  logic signed [OFS_W-1:0] ofs;
  logic [PIX_W-1:0]        old_pix, q_pix;
  logic                    s1_emit, s3_valid, fire, pop;
  sum_t                    s2;
  res_t                    res, head;
  logic [CNT_W-1:0]        count, pending;

  // Every result already buffered or still in the stages holds a buffer slot.
  assign pending      = count + CNT_W'(s1_emit) + CNT_W'(s2.valid) + CNT_W'(s3_valid);
  assign pixels.ready = (pending < CNT_W'(FIFO_DEPTH));
  assign fire         = pixels.valid && pixels.ready;

  amt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .func      (pixels.func),
    .pixel_in  (pixels.pixel_in),
    .item      (item),
    .in_addr   (in_addr),
    .out_addr  (out_addr),
    .ofs       (ofs)
  );

  amt_line_store u_line_store (
    .clk       (clk),
    .wr_en     (fire && item.is_pix),
    .wr_addr   (in_addr),
    .wr_data   (item.pix),
    .rd_addr_a (in_addr),
    .rd_addr_b (out_addr),
    .rd_data_a (old_pix),
    .rd_data_b (q_pix)
  );

  amt_sums u_sums (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (item),
    .old_pix (old_pix),
    .q_pix   (q_pix),
    .s1_emit (s1_emit),
    .s2      (s2)
  );

  amt_thresh u_thresh (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .ofs      (ofs),
    .s3_valid (s3_valid),
    .res      (res)
  );

  amt_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (s3_valid),
    .wr_data (res),
    .rd      (pop),
    .head    (head),
    .count   (count)
  );

  assign results.valid         = (count != '0);
  assign pop                   = results.valid && results.ready;
  assign results.pixel_out     = head.pixel_out;
  assign results.is_border     = head.is_border;
  assign results.last_of_frame = head.last_of_frame;
endmodule

@@ hdl/amt_ctrl.sv @@
// Configuration registers and frame counters; decides per item whether it is
// stored, whether it yields a result, and where that result pixel lies.
// Depends on amt_pkg.
module amt_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [amt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [amt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             fire,
  input  logic                             func,
  input  logic [amt_pkg::PIX_W-1:0]        pixel_in,
  output amt_pkg::item_t                   item,
  output logic [amt_pkg::LS_AW-1:0]        in_addr,
  output logic [amt_pkg::LS_AW-1:0]        out_addr,
  output logic signed [amt_pkg::OFS_W-1:0] ofs
);
  import amt_pkg::*;

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] d);
    logic [CFG_WID_W-1:0] v;
    v = d[CFG_WID_W-1:0];
    if (v == '0) return WID_W'(1);
    else if (v > CFG_WID_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
    else return WID_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] d);
    logic [CFG_HGT_W-1:0] v;
    v = d[CFG_HGT_W-1:0];
    if (v == '0) return ROW_W'(1);
    else if (v > CFG_HGT_W'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT);
    else return ROW_W'(v);
  endfunction

  logic [WID_W-1:0]  img_w;
  logic [ROW_W-1:0]  img_h;
  logic [LAG_W-1:0]  lag;
  logic [COL_W-1:0]  in_col, out_col;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [RECV_W-1:0] received;

  logic [WID_W-1:0]  new_w;
  logic [WID_W-1:0]  in_col_inc, out_col_inc;
  logic              frame_in, is_pix, emit, in_row_end, out_row_end, last, restart;

  assign new_w = clamp_width(cfg_data);

  assign frame_in    = (in_row == img_h);
  assign is_pix      = !func && !frame_in;
  // While pixels stream in, a result is due once the lag is covered; after
  // the frame is in, every item drains one pending result.
  assign emit        = is_pix ? (RECV_W'(lag) <= received) : frame_in;
  assign in_col_inc  = WID_W'(in_col) + WID_W'(1);
  assign out_col_inc = WID_W'(out_col) + WID_W'(1);
  assign in_row_end  = (in_col_inc == img_w);
  assign out_row_end = (out_col_inc == img_w);
  assign last        = emit && out_row_end &&
                       ((ROW_W+1)'(out_row) + (ROW_W+1)'(1) == (ROW_W+1)'(img_h));

  assign restart = (cfg_write && (cfg_index == REG_IMAGE_WIDTH ||
                                  cfg_index == REG_IMAGE_HEIGHT)) ||
                   (fire && last);

  always_comb begin
    item.is_pix    = is_pix;
    item.pix       = pixel_in;
    item.col       = in_col;
    item.row_zero  = (in_row == '0);
    item.row_fresh = (in_row < ROW_W'(LINES));
    item.col_zero  = (in_col == '0);
    item.col_full  = (in_col >= COL_W'(LINES));
    item.emit      = emit;
    item.border    = (out_row < ROW_W'(RADIUS)) ||
                     ((ROW_W+1)'(out_row) + (ROW_W+1)'(RADIUS) >= (ROW_W+1)'(img_h)) ||
                     (out_col < COL_W'(RADIUS)) ||
                     ((WID_W+1)'(out_col) + (WID_W+1)'(RADIUS) >= (WID_W+1)'(img_w));
    item.last      = last;
  end

  assign in_addr  = {in_slot, in_col};
  assign out_addr = {out_slot, out_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= WID_W'(RESET_WIDTH);
      img_h    <= ROW_W'(RESET_HEIGHT);
      ofs      <= OFS_W'(RESET_OFFSET);
      lag      <= LAG_W'(RESET_WIDTH * RADIUS + RADIUS);
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      received <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            img_w <= new_w;
            lag   <= LAG_W'(new_w) * LAG_W'(RADIUS) + LAG_W'(RADIUS);
          end
          REG_IMAGE_HEIGHT:     img_h <= clamp_height(cfg_data);
          REG_THRESHOLD_OFFSET: ofs   <= cfg_data[OFS_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        in_col   <= '0;
        in_row   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
        received <= '0;
      end else if (fire) begin
        if (is_pix) begin
          received <= received + RECV_W'(1);
          if (in_row_end) begin
            in_col  <= '0;
            in_row  <= in_row + ROW_W'(1);
            in_slot <= (in_slot == SLOT_W'(LINES - 1)) ? '0 : in_slot + SLOT_W'(1);
          end else begin
            in_col <= in_col + COL_W'(1);
          end
        end
        if (emit) begin
          if (out_row_end) begin
            out_col  <= '0;
            out_row  <= out_row + ROW_W'(1);
            out_slot <= (out_slot == SLOT_W'(LINES - 1)) ? '0 : out_slot + SLOT_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end
    end
  end

  a_row_range: assert property (@(posedge clk) disable iff (rst) in_row <= img_h)
    else $error("input row counter passed the image height");
  a_col_range: assert property (@(posedge clk) disable iff (rst) WID_W'(in_col) < img_w)
    else $error("input column counter passed the image width");
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
      fire && last |=> in_row == '0 && received == '0 && out_row == '0)
    else $error("frame counters did not restart after the last result");
endmodule

@@ hdl/amt_line_store.sv @@
// Line store: the last 2R+1 lines of pixels, one write port and two read
// ports with registered read data. Depends on amt_pkg.
module amt_line_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [amt_pkg::LS_AW-1:0] wr_addr,
  input  logic [amt_pkg::PIX_W-1:0] wr_data,
  input  logic [amt_pkg::LS_AW-1:0] rd_addr_a,
  input  logic [amt_pkg::LS_AW-1:0] rd_addr_b,
  output logic [amt_pkg::PIX_W-1:0] rd_data_a,
  output logic [amt_pkg::PIX_W-1:0] rd_data_b
);
  import amt_pkg::*;

  logic [PIX_W-1:0] mem [0:LS_DEPTH-1];

  // A read at the address being written returns the old pixel.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end
endmodule

@@ hdl/amt_sums.sv @@
// First pipeline stage: updates the column sum of the incoming pixel and the
// running window sum across the line. Depends on amt_pkg.
module amt_sums (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  amt_pkg::item_t            item,
  input  logic [amt_pkg::PIX_W-1:0] old_pix,
  input  logic [amt_pkg::PIX_W-1:0] q_pix,
  output logic                      s1_emit,
  output amt_pkg::sum_t             s2
);
  import amt_pkg::*;

  logic [CS_W-1:0] col_sums [0:MAX_WIDTH-1];
  logic [CS_W-1:0] win_cols [0:LINES-1];
  logic [WS_W-1:0] window_sum;

  logic            s1_valid;
  item_t           s1;
  logic [CS_W-1:0] cs_rd;
  logic            byp;
  logic [CS_W-1:0] fwd;

  logic [PIX_W-1:0] old_val;
  logic [CS_W-1:0]  cs_old, cs_new, leaving;
  logic [CS_W:0]    cs_sum;
  logic [WS_W-1:0]  ws_base, ws_new;
  logic [WS_W:0]    ws_sum;
  logic             upd;

  assign upd     = s1_valid && s1.is_pix;
  assign old_val = s1.row_fresh ? '0 : old_pix;
  // With a one-pixel line the same column is read again right after its update.
  assign cs_old  = s1.row_zero ? '0 : (byp ? fwd : cs_rd);
  assign cs_sum  = (CS_W+1)'(cs_old) + (CS_W+1)'(s1.pix) - (CS_W+1)'(old_val);
  assign cs_new  = cs_sum[CS_W-1:0];
  assign ws_base = s1.col_zero ? '0 : window_sum;
  assign leaving = s1.col_full ? win_cols[LINES-1] : '0;
  assign ws_sum  = (WS_W+1)'(ws_base) + (WS_W+1)'(cs_new) - (WS_W+1)'(leaving);
  assign ws_new  = ws_sum[WS_W-1:0];
  assign s1_emit = s1_valid && s1.emit;

  always_ff @(posedge clk) begin
    cs_rd <= col_sums[item.col];
    if (upd) col_sums[s1.col] <= cs_new;
  end

  always_ff @(posedge clk) begin
    s1       <= item;
    fwd      <= cs_new;
    s2.ws    <= ws_new;
    s2.pix   <= q_pix;
    s2.border <= s1.border;
    s2.last  <= s1.last;
    if (rst) s2.valid <= 1'b0;
    else s2.valid <= s1_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      byp        <= 1'b0;
      window_sum <= '0;
      for (int i = 0; i < LINES; i++) win_cols[i] <= '0;
    end else begin
      s1_valid <= fire;
      byp      <= fire && upd && (s1.col == item.col);
      if (upd) begin
        window_sum  <= ws_new;
        win_cols[0] <= cs_new;
        for (int i = 1; i < LINES; i++) win_cols[i] <= win_cols[i-1];
      end
    end
  end

  a_full_window: assert property (@(posedge clk) disable iff (rst)
      s1_valid && s1.emit && !s1.border |-> s1.is_pix && s1.col >= COL_W'(2 * RADIUS))
    else $error("interior result issued before its window was complete");
endmodule

@@ hdl/amt_thresh.sv @@
// Second and third pipeline stages: window mean by reciprocal multiply, then the
// compare with mean minus offset; border pixels pass as is. Depends on amt_pkg.
module amt_thresh (
  input  logic                             clk,
  input  logic                             rst,
  input  amt_pkg::sum_t                    s2,
  input  logic signed [amt_pkg::OFS_W-1:0] ofs,
  output logic                             s3_valid,
  output amt_pkg::res_t                    res
);
  import amt_pkg::*;

  logic [WS_W+RECIP_W-1:0] prod;
  logic [PIX_W-1:0]        s3_mean, s3_pix;
  logic                    s3_border, s3_last;
  logic signed [LVL_W-1:0] level, pix_s;

  assign prod = (WS_W+RECIP_W)'(s2.ws) * (WS_W+RECIP_W)'(RECIP_MUL);

  always_ff @(posedge clk) begin
    s3_mean   <= prod[RECIP_SHIFT +: PIX_W];
    s3_pix    <= s2.pix;
    s3_border <= s2.border;
    s3_last   <= s2.last;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= s2.valid;
  end

  assign level = $signed({{(LVL_W-PIX_W){1'b0}}, s3_mean}) - LVL_W'(ofs);
  assign pix_s = $signed({{(LVL_W-PIX_W){1'b0}}, s3_pix});

  always_comb begin
    res.is_border     = s3_border;
    res.last_of_frame = s3_last;
    if (s3_border) res.pixel_out = s3_pix;
    else if (pix_s < level) res.pixel_out = '0;
    else res.pixel_out = PIX_W'(PIX_MAX);
  end
endmodule

@@ hdl/amt_out_fifo.sv @@
// Result buffer between the pipeline and the output channel, so that the
// pipeline keeps running while results wait. Depends on amt_pkg.
module amt_out_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr,
  input  amt_pkg::res_t             wr_data,
  input  logic                      rd,
  output amt_pkg::res_t             head,
  output logic [amt_pkg::CNT_W-1:0] count
);
  import amt_pkg::*;

  res_t               entries [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (rd) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + CNT_W'(wr) - CNT_W'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      wr && !rd |-> count < CNT_W'(FIFO_DEPTH))
    else $error("result buffer written while full");
endmodule
